// ===== src/luhn_pkg.sv =====
// Shared constants, types and helpers for the Luhn card number check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package luhn_pkg;

  localparam int CARD_W          = 54;
  localparam int DIGIT_W         = 4;
  localparam int NUM_DIGITS      = 17;   // 2^54 - 1 has seventeen decimal digits
  localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
  localparam int STEPS_PER_STAGE = 6;
  localparam int NUM_STAGES      = CARD_W / STEPS_PER_STAGE;
  localparam int LEN_W           = 5;
  localparam int LEAD_W          = 7;
  localparam int SUM_W           = 8;    // seventeen digits of at most 9
  localparam int HALF_SUM_W      = 7;
  localparam int LO_DIGITS       = 9;
  localparam int MAX_DIGITS      = 16;
  localparam int CFG_IDX_W       = 1;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(13);
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_e;

  // Partial conversion state: packed BCD digits and the binary bits still to shift in
  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [CARD_W-1:0] bin;
  } b2d_t;

  // Luhn weight of a digit in an even position: double, then add the two digits
  function automatic logic [DIGIT_W-1:0] luhn_dbl(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] dbl;
    begin
      dbl = {d, 1'b0};
      if (dbl >= (DIGIT_W+1)'(10)) begin
        luhn_dbl = DIGIT_W'(dbl - (DIGIT_W+1)'(9));
      end else begin
        luhn_dbl = dbl[DIGIT_W-1:0];
      end
    end
  endfunction

endpackage

// ===== src/luhn_b2d_stage.sv =====
// One registered stage of the binary-to-BCD converter (shift and add-3).
// Depends on luhn_pkg.
`timescale 1ns / 1ps

module luhn_b2d_stage
  import luhn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  b2d_t  data_i,
  output logic  valid_o,
  output b2d_t  data_o
);

  b2d_t data_d, data_q;
  logic valid_q;

  always_comb begin
    logic [BCD_W-1:0]  bcd;
    logic [CARD_W-1:0] bin;
    logic [DIGIT_W-1:0] dig;
    bcd = data_i.bcd;
    bin = data_i.bin;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      // add 3 to every digit of five or more, then shift one bit in
      for (int k = 0; k < NUM_DIGITS; k++) begin
        dig = bcd[k*DIGIT_W +: DIGIT_W];
        if (dig >= DIGIT_W'(5)) begin
          bcd[k*DIGIT_W +: DIGIT_W] = dig + DIGIT_W'(3);
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[CARD_W-1]};
      bin = {bin[CARD_W-2:0], 1'b0};
    end
    data_d.bcd = bcd;
    data_d.bin = bin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/luhn_digit_eval.sv =====
// Two registered stages that turn the BCD digits into the Luhn flag,
// digit count, leading digits and length flag. Depends on luhn_pkg.
`timescale 1ns / 1ps

module luhn_digit_eval
  import luhn_pkg::*;
#(
  parameter int MAX_CARD_DIGITS = MAX_DIGITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [BCD_W-1:0]  bcd_i,
  input  logic [LEN_W-1:0]  min_length_i,
  input  logic [LEN_W-1:0]  max_length_i,
  output logic              valid_o,
  output logic              luhn_ok_o,
  output logic [LEN_W-1:0]  digit_count_o,
  output logic [LEAD_W-1:0] leading_digits_o,
  output logic              length_ok_o
);

  // first stage: weighted half sums, count, leading digits
  logic                  v1_q;
  logic [HALF_SUM_W-1:0] sum_lo_d, sum_lo_q, sum_hi_d, sum_hi_q;
  logic [LEN_W-1:0]      cnt_d, cnt_q;
  logic [LEAD_W-1:0]     lead_d, lead_q;

  // second stage: output register
  logic              v2_q;
  logic              luhn_ok_d, luhn_ok_q;
  logic              len_ok_d, len_ok_q;
  logic [LEN_W-1:0]  cnt2_q;
  logic [LEAD_W-1:0] lead2_q;

  logic [DIGIT_W-1:0] dig [NUM_DIGITS];

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      dig[k] = bcd_i[k*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    logic [DIGIT_W-1:0] w;
    logic [LEN_W-1:0]   top_idx, next_idx;
    logic [LEAD_W-1:0]  hi_d, lo_d;
    sum_lo_d = '0;
    sum_hi_d = '0;
    cnt_d    = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      // rightmost digit is position one (added as is)
      w = (k % 2 == 1) ? luhn_dbl(dig[k]) : dig[k];
      if (k < LO_DIGITS) begin
        sum_lo_d = sum_lo_d + HALF_SUM_W'(w);
      end else begin
        sum_hi_d = sum_hi_d + HALF_SUM_W'(w);
      end
      if (dig[k] != '0) begin
        cnt_d = LEN_W'(k + 1);
      end
    end
    top_idx  = cnt_d - LEN_W'(1);
    next_idx = cnt_d - LEN_W'(2);
    hi_d = LEAD_W'(dig[top_idx]);
    lo_d = LEAD_W'(dig[next_idx]);
    if (cnt_d >= LEN_W'(2)) begin
      lead_d = {hi_d[LEAD_W-4:0], 3'b000} + {hi_d[LEAD_W-2:0], 1'b0} + lo_d;
    end else begin
      lead_d = LEAD_W'(dig[0]);
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(sum_lo_q) + SUM_W'(sum_hi_q);
    luhn_ok_d = 1'b0;
    for (int m = 0; m * 10 <= NUM_DIGITS * 9; m++) begin
      if (sum == SUM_W'(m * 10)) begin
        luhn_ok_d = 1'b1;
      end
    end
    len_ok_d = (cnt_q >= min_length_i) && (cnt_q <= max_length_i) &&
               (cnt_q <= LEN_W'(MAX_CARD_DIGITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_lo_q  <= sum_lo_d;
    sum_hi_q  <= sum_hi_d;
    cnt_q     <= cnt_d;
    lead_q    <= lead_d;
    luhn_ok_q <= luhn_ok_d;
    len_ok_q  <= len_ok_d;
    cnt2_q    <= cnt_q;
    lead2_q   <= lead_q;
  end

  assign valid_o          = v2_q;
  assign luhn_ok_o        = luhn_ok_q;
  assign digit_count_o    = cnt2_q;
  assign leading_digits_o = lead2_q;
  assign length_ok_o      = len_ok_q;

endmodule

// ===== src/luhn_card_number_check_core.sv =====
// Top level of the Luhn card number check: config registers and pipeline.
// Depends on luhn_pkg, luhn_b2d_stage and luhn_digit_eval.
`timescale 1ns / 1ps

// A card number may be started in every clock cycle; busy_o stays low. Each
// item's result appears on done_o and the result ports for one cycle, after
// passing through nine registered binary-to-BCD stages of six shift-add-3
// steps each, then two stages that form the digit sum, count, leading digits
// and length check. There is no backpressure, so take each result when done_o
// is high. Write min and max length only while no item is in flight.

module luhn_card_number_check_core
  import luhn_pkg::*;
#(
  parameter int MAX_CARD_DIGITS = MAX_DIGITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CARD_W-1:0]    card_number_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic                 luhn_ok_o,
  output logic [LEN_W-1:0]     digit_count_o,
  output logic [LEAD_W-1:0]    leading_digits_o,
  output logic                 length_ok_o
);

  localparam int LATENCY = NUM_STAGES + 2;

  logic [LEN_W-1:0] min_length_q, min_length_d;
  logic [LEN_W-1:0] max_length_q, max_length_d;

  logic accept;
  logic stg_valid [NUM_STAGES+1];
  b2d_t stg_data  [NUM_STAGES+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    min_length_d = min_length_q;
    max_length_d = max_length_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_LENGTH: min_length_d = cfg_wdata_i;
        REG_MAX_LENGTH: max_length_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RST;
      max_length_q <= MAX_LENGTH_RST;
    end else begin
      min_length_q <= min_length_d;
      max_length_q <= max_length_d;
    end
  end

  assign stg_valid[0]    = accept;
  assign stg_data[0].bcd = '0;
  assign stg_data[0].bin = card_number_i;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_b2d
    luhn_b2d_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  luhn_digit_eval #(
    .MAX_CARD_DIGITS (MAX_CARD_DIGITS)
  ) u_eval (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (stg_valid[NUM_STAGES]),
    .bcd_i            (stg_data[NUM_STAGES].bcd),
    .min_length_i     (min_length_q),
    .max_length_i     (max_length_q),
    .valid_o          (done_o),
    .luhn_ok_o        (luhn_ok_o),
    .digit_count_o    (digit_count_o),
    .leading_digits_o (leading_digits_o),
    .length_ok_o      (length_ok_o)
  );

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result strobe without a matching start");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && digit_count_o == '0) |-> (luhn_ok_o && leading_digits_o == '0))
    else $error("zero card number gave a wrong result");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && length_ok_o) |-> (digit_count_o <= LEN_W'(MAX_CARD_DIGITS)))
    else $error("length flag set beyond the longest card number");

  a_short_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && digit_count_o <= LEN_W'(1)) |-> (leading_digits_o < LEAD_W'(10)))
    else $error("one-digit number gave two leading digits");

endmodule
